### hdl/cmmr_pkg.sv
package cmmr_pkg;

   localparam int CNT_W       = 12;
   localparam int COLS_W      = 10;
   localparam int IDX_W       = 11;
   localparam int VAL_W       = 16;
   localparam int COL_W       = 9;
   localparam int NUM_W       = CNT_W + COL_W;
   localparam int STEP_W      = $clog2(CNT_W);
   localparam int CSR_DATA_W  = CNT_W;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_SAMPLES_DEF = 2048;
   localparam int MAX_COLUMNS_DEF = 512;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = CNT_W'(2048);
   localparam logic [COLS_W-1:0] COLUMN_COUNT_RST = COLS_W'(336);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_COUNT = 1'b0,
      CSR_COLUMN_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_BAD_COLUMN = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_A,
      ST_DIV_B,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

### hdl/column_min_max_reduction_top.sv
// Write word: stored as it is taken; the next word is accepted in the following cycle.
// Query word: loaded, then the shared divide step finds the start and end of the span,
// the span is read from the store, and the result is handed over. Bad column or empty
// record: answered with no divide or scan, min and max zero. A result waits in an output
// register while the next word is taken. Synchronous active-high reset restores the
// register defaults (2048 samples, 336 columns); the sample store is not cleared.
module column_min_max_reduction_top #(
   parameter int MAX_SAMPLES = cmmr_pkg::MAX_SAMPLES_DEF,
   parameter int MAX_COLUMNS = cmmr_pkg::MAX_COLUMNS_DEF,
   parameter int SAMPLE_BITS = cmmr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_write_en,
   input  logic [cmmr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cmmr_pkg::CSR_DATA_W-1:0]  csr_wdata,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [cmmr_pkg::IDX_W-1:0]       req_sample_index,
   input  logic [cmmr_pkg::VAL_W-1:0]       req_sample_value,
   input  logic [cmmr_pkg::COL_W-1:0]       req_column,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cmmr_pkg::VAL_W-1:0]       rsp_col_min,
   output logic [cmmr_pkg::VAL_W-1:0]       rsp_col_max,
   output logic                             rsp_status
);

   localparam int CNT_W  = cmmr_pkg::CNT_W;
   localparam int COLS_W = cmmr_pkg::COLS_W;
   localparam int NUM_W  = cmmr_pkg::NUM_W;
   localparam int STEP_W = cmmr_pkg::STEP_W;
   localparam int VAL_W  = cmmr_pkg::VAL_W;
   localparam int ADDR_W = $clog2(MAX_SAMPLES);

   localparam logic [CNT_W-1:0] N_CAP = (MAX_SAMPLES >= (1 << CNT_W)) ?
                                        {CNT_W{1'b1}} : CNT_W'(MAX_SAMPLES);
   localparam logic [COLS_W-1:0] C_CAP = (MAX_COLUMNS >= (1 << COLS_W)) ?
                                         {COLS_W{1'b1}} : COLS_W'(MAX_COLUMNS);
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(CNT_W - 1);

   cmmr_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]       n_ff, n_in;
   logic [COLS_W-1:0]      cols_ff, cols_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [COLS_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]       q_ff, q_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       end_ff, end_in;
   logic                   pend_ff, pend_in;
   logic                   first_ff, first_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_min_ff, rsp_min_in;
   logic [VAL_W-1:0]       rsp_max_ff, rsp_max_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic [SAMPLE_BITS-1:0] sample_store [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;

   logic                   req_take;
   logic                   col_bad;
   logic [NUM_W-1:0]       prod;
   logic [NUM_W-1:0]       num_next;
   logic [CNT_W-1:0]       num_lo;
   logic [COLS_W:0]        trial;
   logic                   qbit;
   logic [COLS_W-1:0]      rem_step;
   logic [CNT_W-1:0]       quot;
   logic [CNT_W-1:0]       b_wide;
   logic [CNT_W-1:0]       b_clip;
   logic                   slot_free;

   // configuration registers, clipped to their caps on write (column count: low 10 bits first)
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff    <= cmmr_pkg::SAMPLE_COUNT_RST;
         cols_ff <= cmmr_pkg::COLUMN_COUNT_RST;
      end else begin
         n_ff    <= n_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      n_in    = n_ff;
      cols_in = cols_ff;
      if (csr_write_en) begin
         unique case (cmmr_pkg::csr_index_type'(csr_index))
            cmmr_pkg::CSR_SAMPLE_COUNT: begin
               n_in = (csr_wdata > N_CAP) ? N_CAP : csr_wdata;
            end
            cmmr_pkg::CSR_COLUMN_COUNT: begin
               cols_in = (csr_wdata[COLS_W-1:0] > C_CAP) ? C_CAP : csr_wdata[COLS_W-1:0];
            end
            default: begin
               n_in = n_ff;
            end
         endcase
      end
   end

   // sample store
   assign req_ready = (state_ff == cmmr_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign mem_we    = req_take && (req_func == cmmr_pkg::FUNC_WRITE) &&
                      (int'(req_sample_index) < MAX_SAMPLES);
   assign wr_addr   = ADDR_W'(req_sample_index);
   assign rd_addr   = ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[wr_addr] <= req_sample_value[SAMPLE_BITS-1:0];
      end
      rdata_ff <= sample_store[rd_addr];
   end

   // shared divide step: one quotient bit per cycle
   assign col_bad  = ({1'b0, req_column} >= cols_ff);
   assign prod     = NUM_W'(n_ff) * NUM_W'(req_column);
   assign num_next = num_ff + NUM_W'(n_ff);
   assign num_lo   = num_ff[CNT_W-1:0];
   assign trial    = {rem_ff, num_lo[step_ff]};
   assign qbit     = (trial >= {1'b0, cols_ff});
   assign rem_step = qbit ? COLS_W'(trial - {1'b0, cols_ff}) : trial[COLS_W-1:0];
   assign quot     = {q_ff[CNT_W-2:0], qbit};
   assign b_wide   = (quot <= idx_ff) ? (idx_ff + CNT_W'(1)) : quot;
   assign b_clip   = (b_wide > n_ff) ? n_ff : b_wide;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmmr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      pend_ff       <= pend_in;
      first_ff      <= first_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      err_ff        <= err_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      pend_in       = pend_ff;
      first_in      = first_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      err_in        = err_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         cmmr_pkg::ST_IDLE: begin
            if (req_take && (req_func == cmmr_pkg::FUNC_QUERY)) begin
               min_in   = '0;
               max_in   = '0;
               err_in   = col_bad;
               first_in = 1'b1;
               pend_in  = 1'b0;
               num_in   = prod;
               rem_in   = COLS_W'(prod[NUM_W-1:CNT_W]);
               q_in     = '0;
               step_in  = STEP_TOP;
               if (col_bad || (n_ff == '0)) begin
                  state_in = cmmr_pkg::ST_FINISH;
               end else begin
                  state_in = cmmr_pkg::ST_DIV_A;
               end
            end
         end
         cmmr_pkg::ST_DIV_A: begin
            rem_in  = rem_step;
            q_in    = quot;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               idx_in   = quot;
               num_in   = num_next;
               rem_in   = COLS_W'(num_next[NUM_W-1:CNT_W]);
               q_in     = '0;
               step_in  = STEP_TOP;
               state_in = cmmr_pkg::ST_DIV_B;
            end
         end
         cmmr_pkg::ST_DIV_B: begin
            rem_in  = rem_step;
            q_in    = quot;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               end_in   = b_clip;
               state_in = cmmr_pkg::ST_SCAN;
            end
         end
         cmmr_pkg::ST_SCAN: begin
            if (pend_ff) begin
               first_in = 1'b0;
               if (first_ff || (rdata_ff < min_ff)) begin
                  min_in = rdata_ff;
               end
               if (first_ff || (rdata_ff > max_ff)) begin
                  max_in = rdata_ff;
               end
            end
            if (idx_ff != end_ff) begin
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = cmmr_pkg::ST_FINISH;
            end
         end
         cmmr_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_min_in    = VAL_W'(min_ff);
               rsp_max_in    = VAL_W'(max_ff);
               rsp_status_in = err_ff ? cmmr_pkg::STATUS_BAD_COLUMN : cmmr_pkg::STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = cmmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cmmr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_col_min = rsp_min_ff;
   assign rsp_col_max = rsp_max_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef SYNTHESIS
   a_bad_column_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cmmr_pkg::STATUS_BAD_COLUMN) |->
         (rsp_col_min == '0) && (rsp_col_max == '0))
      else $error("bad column answer carries nonzero data");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_col_min <= rsp_col_max))
      else $error("column minimum above maximum");

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cmmr_pkg::ST_SCAN) |-> (idx_ff <= end_ff) && (end_ff <= n_ff))
      else $error("scan index outside span");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == cmmr_pkg::FUNC_QUERY) |=> !req_ready)
      else $error("query did not hold off the next word");
`endif

endmodule
